// ===== rtl/trtt_pkg.sv =====
// ----------------------------------------------------------------------------
// Tag region translation table package
// Shared types, request and status codes, and table limits.
// ----------------------------------------------------------------------------
package trtt_pkg;

  localparam int unsigned MaxRegions = 16;
  localparam int unsigned AddrW = 64;

  typedef enum logic [1:0] {
    REQ_MAP = 2'd0,
    REQ_M2T = 2'd1,
    REQ_T2M = 2'd2,
    REQ_TST = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MISS    = 3'd1,
    ST_TAG_OVL = 3'd2,
    ST_MAP_OVL = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [AddrW-1:0] lookup_addr;
    logic [AddrW-1:0] region_base;
    logic [AddrW-1:0] region_tag_base;
    logic [AddrW-1:0] region_size;
    logic             allow_remap;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] result_addr;
    logic             in_tag_region;
    logic [2:0]       status;
  } rsp_t;

  // Half-open overlap of two nonempty, non-wrapping ranges.
  function automatic logic ovl(logic [AddrW-1:0] a, logic [AddrW-1:0] la,
                               logic [AddrW-1:0] b, logic [AddrW-1:0] lb);
    logic [AddrW-1:0] alast;
    logic [AddrW-1:0] blast;
    alast = a + (la - 1'b1);
    blast = b + (lb - 1'b1);
    return (a <= blast) && (b <= alast);
  endfunction

endpackage

// ===== rtl/trtt_if.sv =====
// ----------------------------------------------------------------------------
// Tag region translation table channels
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface trtt_req_if;
  logic            valid;
  logic            ready;
  trtt_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trtt_rsp_if;
  logic            valid;
  logic            ready;
  trtt_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/trtt_front.sv =====
// ----------------------------------------------------------------------------
// Tag region translation table front end
// Accepts requests, clamps map sizes and queues them in a two-entry FIFO.
// ----------------------------------------------------------------------------
module trtt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  trtt_req_if.sink         in_i,
  output logic             q_valid_o,
  output trtt_pkg::req_t   q_data_o,
  input  logic             q_pop_i
);

  trtt_pkg::req_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d;
  logic       wr_q, wr_d;
  logic       push;
  trtt_pkg::req_t cl;
  logic [trtt_pkg::AddrW-1:0] sz, lim;

  always_comb begin
    cl = in_i.data;
    sz = in_i.data.region_size;
    lim = '0 - in_i.data.region_base;
    if (in_i.data.region_base != '0 && sz > lim) begin
      sz = lim;
    end
    lim = '0 - in_i.data.region_tag_base;
    if (in_i.data.region_tag_base != '0 && sz > lim) begin
      sz = lim;
    end
    cl.region_size = sz;
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push = in_i.valid && in_i.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
    rd_d = rd_q ^ q_pop_i;
    wr_d = wr_q ^ push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cl;
    end
  end

endmodule

// ===== rtl/trtt_back.sv =====
// ----------------------------------------------------------------------------
// Tag region translation table back end
// Holds the region table, executes lookups and map requests one at a time,
// visiting one entry per cycle for the remap cuts.
// ----------------------------------------------------------------------------
module trtt_back #(
  parameter int unsigned MaxRegions = trtt_pkg::MaxRegions
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  trtt_pkg::req_t  q_data_i,
  output logic            q_pop_o,
  trtt_rsp_if.source      out_o
);

  localparam int unsigned IdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int unsigned AW = trtt_pkg::AddrW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_COPY = 6'b000010,
    S_CUT  = 6'b000100,
    S_INS  = 6'b001000,
    S_COMM = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [MaxRegions-1:0] v_q, wv_q, wv_d;
  logic [AW-1:0] m_q [MaxRegions];
  logic [AW-1:0] t_q [MaxRegions];
  logic [AW-1:0] s_q [MaxRegions];
  logic [AW-1:0] wm_q [MaxRegions];
  logic [AW-1:0] wt_q [MaxRegions];
  logic [AW-1:0] ws_q [MaxRegions];

  trtt_pkg::req_t r_q;
  logic [IdxW-1:0] idx_q;
  logic            pass_q;
  logic            ovalid_q, ovalid_d;
  trtt_pkg::rsp_t  odata_q, odata_d;

  logic [MaxRegions-1:0] tag_hit, map_hit, m2t_hit, t2m_hit;
  logic [AW-1:0] m2t_res [MaxRegions];
  logic [AW-1:0] t2m_res [MaxRegions];
  logic            take;
  trtt_pkg::rsp_t  lk;
  logic            found;

  always_comb begin
    for (int i = 0; i < MaxRegions; i++) begin
      tag_hit[i] = v_q[i] && (trtt_pkg::ovl(t_q[i], s_q[i], q_data_i.region_base,
                   q_data_i.region_size) || trtt_pkg::ovl(t_q[i], s_q[i],
                   q_data_i.region_tag_base, q_data_i.region_size));
      map_hit[i] = v_q[i] && (trtt_pkg::ovl(m_q[i], s_q[i], q_data_i.region_base,
                   q_data_i.region_size) || trtt_pkg::ovl(m_q[i], s_q[i],
                   q_data_i.region_tag_base, q_data_i.region_size));
      m2t_hit[i] = v_q[i] && q_data_i.lookup_addr >= m_q[i] &&
                   (q_data_i.lookup_addr - m_q[i]) < s_q[i];
      t2m_hit[i] = v_q[i] && q_data_i.lookup_addr >= t_q[i] &&
                   (q_data_i.lookup_addr - t_q[i]) < s_q[i];
      m2t_res[i] = q_data_i.lookup_addr - m_q[i] + t_q[i];
      t2m_res[i] = q_data_i.lookup_addr - t_q[i] + m_q[i];
    end
  end

  always_comb begin
    lk = '0;
    lk.status = trtt_pkg::ST_MISS;
    found = 1'b0;
    for (int i = 0; i < MaxRegions; i++) begin
      if (!found) begin
        if (q_data_i.req_type == trtt_pkg::REQ_M2T && m2t_hit[i]) begin
          lk.result_addr = m2t_res[i];
          lk.status = trtt_pkg::ST_OK;
          found = 1'b1;
        end else if (q_data_i.req_type == trtt_pkg::REQ_T2M && t2m_hit[i]) begin
          lk.result_addr = t2m_res[i];
          lk.status = trtt_pkg::ST_OK;
          found = 1'b1;
        end else if (q_data_i.req_type == trtt_pkg::REQ_TST && t2m_hit[i]) begin
          lk.in_tag_region = 1'b1;
          found = 1'b1;
        end
      end
    end
    if (q_data_i.req_type == trtt_pkg::REQ_TST) begin
      lk.status = trtt_pkg::ST_OK;
    end
  end

  // Cut unit for one work entry.
  logic [AW-1:0] cb, cl, mb, ml, tb, sz, off;
  logic          cut_ovl;
  logic [MaxRegions-1:0] free_v;
  logic [IdxW-1:0] free_idx;
  logic            free_ok;

  always_comb begin
    cb = pass_q ? r_q.region_tag_base : r_q.region_base;
    cl = cb + (r_q.region_size - 1'b1);
    mb = wm_q[idx_q];
    tb = wt_q[idx_q];
    sz = ws_q[idx_q];
    ml = mb + (sz - 1'b1);
    off = cl + 1'b1 - mb;
    cut_ovl = wv_q[idx_q] && trtt_pkg::ovl(mb, sz, cb, r_q.region_size);
    free_v = wv_q;
    if (cut_ovl && !(mb < cb)) begin
      free_v[idx_q] = 1'b0;
    end
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = MaxRegions - 1; i >= 0; i--) begin
      if (!free_v[i]) begin
        free_ok = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign take = (state_q == S_IDLE) && q_valid_i && !ovalid_q;
  assign q_pop_o = take;
  assign out_o.valid = ovalid_q;
  assign out_o.data = odata_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take && q_data_i.req_type == trtt_pkg::REQ_MAP &&
            q_data_i.region_size != '0 && tag_hit == '0 &&
            (q_data_i.allow_remap || map_hit == '0)) begin
          state_d = S_COPY;
        end
      end
      S_COPY: state_d = S_CUT;
      S_CUT: begin
        if (cut_ovl && ml > cl && !free_ok) begin
          state_d = S_OUT;
        end else if (idx_q == IdxW'(MaxRegions - 1) && pass_q) begin
          state_d = S_INS;
        end
      end
      S_INS: state_d = free_ok ? S_COMM : S_OUT;
      S_COMM: state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    wv_d = wv_q;
    odata_d = odata_q;
    ovalid_d = ovalid_q;
    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          odata_d = lk;
          if (q_data_i.req_type == trtt_pkg::REQ_MAP) begin
            odata_d = '0;
            if (q_data_i.region_size == '0) begin
              odata_d.status = trtt_pkg::ST_OK;
            end else if (tag_hit != '0) begin
              odata_d.status = trtt_pkg::ST_TAG_OVL;
            end else if (!q_data_i.allow_remap && map_hit != '0) begin
              odata_d.status = trtt_pkg::ST_MAP_OVL;
            end
          end
          if (state_d == S_IDLE) begin
            ovalid_d = 1'b1;
          end
        end
      end
      S_COPY: wv_d = v_q;
      S_CUT: begin
        if (cut_ovl) begin
          wv_d = free_v;
          if (ml > cl && free_ok) begin
            wv_d[free_idx] = 1'b1;
          end else if (ml > cl) begin
            odata_d.status = trtt_pkg::ST_FULL;
          end
        end
      end
      S_INS: begin
        if (free_ok) begin
          wv_d[free_idx] = 1'b1;
          odata_d.status = trtt_pkg::ST_OK;
        end else begin
          odata_d.status = trtt_pkg::ST_FULL;
        end
      end
      S_OUT: ovalid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      v_q <= '0;
      wv_q <= '0;
      ovalid_q <= 1'b0;
      idx_q <= '0;
      pass_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wv_q <= wv_d;
      ovalid_q <= ovalid_d;
      unique case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          pass_q <= 1'b0;
        end
        S_CUT: begin
          if (idx_q == IdxW'(MaxRegions - 1)) begin
            idx_q <= '0;
            pass_q <= 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_COMM: v_q <= wv_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    if (take) begin
      r_q <= q_data_i;
    end
    unique case (state_q)
      S_COPY: begin
        for (int i = 0; i < MaxRegions; i++) begin
          wm_q[i] <= m_q[i];
          wt_q[i] <= t_q[i];
          ws_q[i] <= s_q[i];
        end
      end
      S_CUT: begin
        if (cut_ovl) begin
          if (mb < cb) begin
            ws_q[idx_q] <= cb - mb;
          end
          if (ml > cl && free_ok) begin
            wm_q[free_idx] <= mb + off;
            wt_q[free_idx] <= tb + off;
            ws_q[free_idx] <= sz - off;
          end
        end
      end
      S_INS: begin
        if (free_ok) begin
          wm_q[free_idx] <= r_q.region_base;
          wt_q[free_idx] <= r_q.region_tag_base;
          ws_q[free_idx] <= r_q.region_size;
        end
      end
      S_COMM: begin
        for (int i = 0; i < MaxRegions; i++) begin
          m_q[i] <= wm_q[i];
          t_q[i] <= wt_q[i];
          s_q[i] <= ws_q[i];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/tag_region_translation_table.sv =====
// ----------------------------------------------------------------------------
// Tag region translation table
// Maps memory ranges to tag ranges and translates addresses both ways.
// ----------------------------------------------------------------------------
// Lookups are resolved at the front queue head and registered in the response
// register, and the back end serves one item at a time. A map request that
// passes its overlap checks walks the table twice, one entry per cycle, unless
// it stops for lack of a free entry; this walk sets the cost of remapping.
module tag_region_translation_table #(
  parameter int unsigned MaxRegions = trtt_pkg::MaxRegions
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  trtt_req_if.sink   req_i,
  trtt_rsp_if.source rsp_o
);

  logic           q_valid;
  logic           q_pop;
  trtt_pkg::req_t q_data;

  trtt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (req_i),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  trtt_back #(.MaxRegions(MaxRegions)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_o     (rsp_o)
  );

endmodule

// ===== rtl/trtt_checker.sv =====
// ----------------------------------------------------------------------------
// Tag region translation table checker
// Port level checks, bound to the top level.
// ----------------------------------------------------------------------------
module trtt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input trtt_pkg::rsp_t rsp_data_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("Response changed while stalled.");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_data_i.status <= trtt_pkg::ST_FULL)
    else $error("Undefined status.");

  a_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.in_tag_region |->
      rsp_data_i.status == trtt_pkg::ST_OK && rsp_data_i.result_addr == '0)
    else $error("Tag test response malformed.");

  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.status != trtt_pkg::ST_OK |-> rsp_data_i.result_addr == '0)
    else $error("Failed request returned an address.");

endmodule

bind tag_region_translation_table trtt_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
